// ===== sv/slffe_pkg.sv =====
`default_nettype none

package slffe_pkg;

  // item widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned NUM_WORDS = 12;
  localparam int unsigned OUT_W     = NUM_WORDS * WORD_W;
  localparam int unsigned COUNT_W   = 9;

  // payload bytes that feed the result words; byte 0 (length) is kept apart
  localparam int unsigned STORE_LO = 9;
  localparam int unsigned STORE_HI = 68;

  // payload offset of the lowest byte of each result word
  localparam int unsigned WORD_OFFSET [NUM_WORDS] = '{
    9, 13, 17, 33, 37, 41, 45, 49, 53, 57, 61, 65
  };

  // configuration
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1
  } cfg_reg_t;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'h55;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'haa;

  // parser phase
  typedef enum logic [2:0] {
    PH_SYNC1 = 3'b001,
    PH_SYNC2 = 3'b010,
    PH_DATA  = 3'b100
  } phase_t;

endpackage

`default_nettype wire

// ===== sv/sync_length_frame_field_extractor_unit.sv =====
`default_nettype none

// channel  | dir | ports                          | payload
// in_      | in  | in_tvalid/in_tready/in_tdata   | one received byte
// out_     | out | out_tvalid/out_tready/out_tdata| twelve 32-bit words, one per frame
// cfg_     | in  | cfg_we/cfg_addr/cfg_wdata      | sync_first, sync_second
//
// one byte is taken per cycle while in_tready is high; the parser state updates in
// the cycle the byte is accepted, and a frame's result is registered with its last
// byte, visible from the cycle after. in_tready drops only when the byte in hand
// would end a frame while the previous result is held by a stalled out_ side
// rst_n is synchronous and active low: parser back to first-sync hunt, store zeroed,
// sync bytes back to 0x55 and 0xaa, no result pending

module sync_length_frame_field_extractor_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [slffe_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [slffe_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // byte stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [slffe_pkg::BYTE_W-1:0]        in_tdata,   // rx_byte
  // result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // from bit 0 up: rate_x_word, rate_y_word, rate_z_word, vel_north_word,
  // vel_up_word, vel_east_word, altitude_word, longitude_word, latitude_word,
  // angle_a_word, yaw_word, angle_c_word
  output logic [slffe_pkg::OUT_W-1:0]              out_tdata
);

  localparam int unsigned BW = slffe_pkg::BYTE_W;
  localparam int unsigned CW = slffe_pkg::COUNT_W;

  // configuration registers
  logic [BW-1:0] sync_first_r;
  logic [BW-1:0] sync_second_r;

  // parser state
  slffe_pkg::phase_t phase_r, phase_nxt;
  logic [CW-1:0]     byte_count_r, byte_count_nxt;
  logic [BW-1:0]     frame_length_r, frame_length_nxt;

  // payload bytes that feed the result words
  logic [BW-1:0] store_r [slffe_pkg::STORE_LO:slffe_pkg::STORE_HI];

  // result register
  logic                         out_valid_r;
  logic [slffe_pkg::OUT_W-1:0]  out_data_r, out_data_nxt;

  logic accept;
  logic frame_end;
  logic out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= slffe_pkg::SYNC_FIRST_RESET;
      sync_second_r <= slffe_pkg::SYNC_SECOND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        slffe_pkg::REG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        slffe_pkg::REG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        default: ;  // unknown index, ignored
      endcase
    end
  end

  // the byte in hand closes the frame once length + 2 payload bytes are counted;
  // that byte itself is neither stored nor checked against the sync bytes
  assign frame_end = (phase_r == slffe_pkg::PH_DATA) &&
                     (byte_count_r == ({1'b0, frame_length_r} + CW'(2)));

  // a pending result that is not being taken blocks only a frame-ending byte
  assign out_busy  = out_valid_r && !out_tready;
  assign in_tready = !(out_busy && frame_end);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    phase_nxt        = phase_r;
    byte_count_nxt   = byte_count_r;
    frame_length_nxt = frame_length_r;
    unique case (phase_r)
      slffe_pkg::PH_SYNC2: begin
        // a wrong second byte is not retried as a first sync byte
        phase_nxt = (in_tdata == sync_second_r) ? slffe_pkg::PH_DATA
                                                : slffe_pkg::PH_SYNC1;
      end
      slffe_pkg::PH_DATA: begin
        if (frame_end) begin
          phase_nxt      = slffe_pkg::PH_SYNC1;
          byte_count_nxt = '0;
        end else begin
          byte_count_nxt = byte_count_r + CW'(1);
          // the first payload byte is the frame length
          if (byte_count_r == '0) begin
            frame_length_nxt = in_tdata;
          end
        end
      end
      default: begin
        phase_nxt = (in_tdata == sync_first_r) ? slffe_pkg::PH_SYNC2
                                               : slffe_pkg::PH_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= slffe_pkg::PH_SYNC1;
      byte_count_r   <= '0;
      frame_length_r <= '0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      byte_count_r   <= byte_count_nxt;
      frame_length_r <= frame_length_nxt;
    end
  end

  // store: each byte has its own write decode; the whole store zeroes at frame end
  // bytes beyond the last read offset are never looked at, so they are dropped
  always_ff @(posedge clk) begin
    for (int i = slffe_pkg::STORE_LO; i <= slffe_pkg::STORE_HI; i++) begin
      if (!rst_n || (accept && frame_end)) begin
        store_r[i] <= '0;
      end else if (accept && (phase_r == slffe_pkg::PH_DATA) &&
                   (byte_count_r == CW'(i))) begin
        store_r[i] <= in_tdata;
      end
    end
  end

  // little-endian words at fixed payload offsets
  always_comb begin
    for (int k = 0; k < slffe_pkg::NUM_WORDS; k++) begin
      out_data_nxt[k*slffe_pkg::WORD_W +: slffe_pkg::WORD_W] = {
        store_r[slffe_pkg::WORD_OFFSET[k] + 3],
        store_r[slffe_pkg::WORD_OFFSET[k] + 2],
        store_r[slffe_pkg::WORD_OFFSET[k] + 1],
        store_r[slffe_pkg::WORD_OFFSET[k]]
      };
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && frame_end) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && frame_end) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== sv/slffe_checker.sv =====
`default_nettype none

module slffe_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [slffe_pkg::OUT_W-1:0]       out_tdata
);

  // a held result keeps its words until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output back-pressure");

  // a new result is always caused by a byte taken in the cycle before
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("result without a frame-ending item");

endmodule

bind sync_length_frame_field_extractor_unit slffe_checker u_slffe_checker (.*);

`default_nettype wire
